[rtl/ips_pkg.sv]
package ips_pkg;

    // Port and field widths; the tdata widths are whole bytes
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_INDEX_W = 2;
    localparam int THR_W       = 7;
    localparam int PCT_W       = 7;
    localparam int MIN_OF_DAY_W = 11;

    localparam int unsigned ADC_FULL_SCALE_DEF = 4095;

    // Event kinds carried in tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Button codes
    localparam logic [2:0] BTN_MODE  = 3'd0;
    localparam logic [2:0] BTN_UP    = 3'd1;
    localparam logic [2:0] BTN_DOWN  = 3'd2;
    localparam logic [2:0] BTN_LEFT  = 3'd3;
    localparam logic [2:0] BTN_RIGHT = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OPT_THR = 2'd1;

    // Reset values
    localparam logic [THR_W-1:0] LOW_THR_RST = 7'd30;
    localparam logic [THR_W-1:0] OPT_THR_RST = 7'd50;
    localparam logic [4:0] START_HOUR_RST   = 5'd8;
    localparam logic [5:0] START_MINUTE_RST = 6'd0;
    localparam logic [4:0] STOP_HOUR_RST    = 5'd9;
    localparam logic [5:0] STOP_MINUTE_RST  = 6'd0;

    localparam logic [4:0] LAST_HOUR   = 5'd23;
    localparam logic [5:0] LAST_MINUTE = 6'd59;

    typedef enum logic [2:0] {
        PH_NORMAL     = 3'd0,
        PH_START_HOUR = 3'd1,
        PH_START_MIN  = 3'd2,
        PH_STOP_HOUR  = 3'd3,
        PH_STOP_MIN   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
    } time_t;

    // One event after scaling, as it enters the control stage
    typedef struct packed {
        logic             op;
        logic [2:0]       button;
        logic [PCT_W-1:0] percent;
        logic [4:0]       hour;
        logic [5:0]       minute;
    } event_t;

    typedef struct packed {
        logic             pump_on;
        logic [PCT_W-1:0] moisture_percent;
        logic             timed_mode;
        phase_t           editor_state;
        time_t            start_time;
        time_t            stop_time;
    } result_t;

endpackage

[rtl/irrigation_pump_scheduler.sv]
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: operation; tdata: event fields
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: pump, percent, mode, editor, times
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data (thresholds)
//
// One event per cycle is accepted while m_axis is not stalled, and one result per event leaves
// after the input register, the moisture scaling multiplier, then the control stage.
// Reset gives auto mode, pump off, window 08:00 to 09:00, thresholds 30 and 50.
// A stall on m_axis fills the empty stages first; s_axis_tready falls only when all three
// stages hold an event.
module irrigation_pump_scheduler #(
    parameter int unsigned ADC_FULL_SCALE = ips_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] button, [14:3] moisture_raw, [19:15] clock_hour, [25:20] clock_minute
    input  logic [ips_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] operation
    input  logic                              s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] pump_on, [7:1] moisture_percent, [8] timed_mode, [11:9] editor_state,
    // [16:12] start_hour_out, [22:17] start_minute_out, [27:23] stop_hour_out,
    // [33:28] stop_minute_out
    output logic [ips_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ips_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ips_pkg::THR_W-1:0]         cfg_data
);

    logic                       a_valid_reg;
    logic                       a_op_reg;
    logic [2:0]                 a_button_reg;
    logic [11:0]                a_raw_reg;
    logic [4:0]                 a_hour_reg;
    logic [5:0]                 a_minute_reg;
    logic                       b_valid_reg;
    ips_pkg::event_t            b_ev_reg;
    logic                       m_valid_reg;
    ips_pkg::result_t           m_res_reg;
    logic [ips_pkg::THR_W-1:0]  low_thr_reg;
    logic [ips_pkg::THR_W-1:0]  opt_thr_reg;

    logic                       s_fire;
    logic                       a_fire;
    logic                       b_fire;
    logic                       out_ready;
    logic                       b_ready;
    logic [ips_pkg::PCT_W-1:0]  a_percent;
    ips_pkg::result_t           ctrl_res;

    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign b_fire        = b_valid_reg && out_ready;
    assign b_ready       = !b_valid_reg || out_ready;
    assign a_fire        = a_valid_reg && b_ready;
    assign s_axis_tready = !a_valid_reg || b_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    ips_scale #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_scale (
        .moisture_raw     (a_raw_reg),
        .moisture_percent (a_percent)
    );

    ips_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (b_fire),
        .ev      (b_ev_reg),
        .low_thr (low_thr_reg),
        .opt_thr (opt_thr_reg),
        .res     (ctrl_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_fire)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_fire)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_op_reg     <= s_axis_tuser;
            a_button_reg <= s_axis_tdata[2:0];
            a_raw_reg    <= s_axis_tdata[14:3];
            a_hour_reg   <= s_axis_tdata[19:15];
            a_minute_reg <= s_axis_tdata[25:20];
        end
        if (a_fire)
        begin
            b_ev_reg.op      <= a_op_reg;
            b_ev_reg.button  <= a_button_reg;
            b_ev_reg.percent <= a_percent;
            b_ev_reg.hour    <= a_hour_reg;
            b_ev_reg.minute  <= a_minute_reg;
        end
        if (b_fire)
        begin
            m_res_reg <= ctrl_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg <= ips_pkg::LOW_THR_RST;
            opt_thr_reg <= ips_pkg::OPT_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ips_pkg::REG_LOW_THR: low_thr_reg <= cfg_data;
                ips_pkg::REG_OPT_THR: opt_thr_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            m_res_reg.stop_time.minute,
                            m_res_reg.stop_time.hour,
                            m_res_reg.start_time.minute,
                            m_res_reg.start_time.hour,
                            m_res_reg.editor_state,
                            m_res_reg.timed_mode,
                            m_res_reg.moisture_percent,
                            m_res_reg.pump_on};

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_percent <= 7'd100))
        else $error("scaled moisture percent above 100");

    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_res_reg.start_time.hour <= ips_pkg::LAST_HOUR)
                     && (m_res_reg.stop_time.hour <= ips_pkg::LAST_HOUR)
                     && (m_res_reg.start_time.minute <= ips_pkg::LAST_MINUTE)
                     && (m_res_reg.stop_time.minute <= ips_pkg::LAST_MINUTE))
        else $error("watering window time out of range");

    a_press_keeps_percent: assert property (@(posedge clk) disable iff (!rst_n)
        b_fire && (b_ev_reg.op == ips_pkg::OP_PRESS) && m_valid_reg && m_axis_tready
        |=> $stable(m_axis_tdata[7:1]))
        else $error("button press changed the moisture percent");

endmodule

[rtl/ips_scale.sv]
module ips_scale #(
    parameter int unsigned ADC_FULL_SCALE = ips_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic [11:0]                moisture_raw,
    output logic [ips_pkg::PCT_W-1:0]  moisture_percent
);

    localparam int FS_W  = $clog2(ADC_FULL_SCALE + 1);
    localparam int CMP_W = (FS_W > 12) ? FS_W : 12;
    // 100 * FS^2 < 2^SH keeps the rounded-up reciprocal exact over every numerator.
    localparam int SH    = 2 * FS_W + 7;
    localparam int M_W   = SH - FS_W + 8;
    localparam int P_W   = FS_W + M_W;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(ADC_FULL_SCALE) - 64'd1)
                                    / 64'(ADC_FULL_SCALE);
    localparam logic [M_W-1:0] MULT = M_W'(RECIP * 64'd100);

    logic [CMP_W-1:0] raw_ext;
    logic [CMP_W-1:0] fs_ext;
    logic             at_full;
    logic [FS_W-1:0]  diff;
    logic [P_W-1:0]   prod;

    assign raw_ext = CMP_W'(moisture_raw);
    assign fs_ext  = CMP_W'(ADC_FULL_SCALE);
    assign at_full = (raw_ext >= fs_ext);
    assign diff    = FS_W'(fs_ext - raw_ext);
    assign prod    = P_W'(diff) * P_W'(MULT);

    assign moisture_percent = at_full ? '0 : prod[SH +: ips_pkg::PCT_W];

endmodule

[rtl/ips_ctrl.sv]
module ips_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  ips_pkg::event_t            ev,
    input  logic [ips_pkg::THR_W-1:0]  low_thr,
    input  logic [ips_pkg::THR_W-1:0]  opt_thr,
    output ips_pkg::result_t           res
);

    logic                       pump_reg;
    logic                       pump_next;
    logic                       mode_reg;
    logic                       mode_next;
    ips_pkg::phase_t            phase_reg;
    ips_pkg::phase_t            phase_next;
    ips_pkg::time_t             start_reg;
    ips_pkg::time_t             start_next;
    ips_pkg::time_t             stop_reg;
    ips_pkg::time_t             stop_next;
    logic [ips_pkg::PCT_W-1:0]  pct_reg;
    logic [ips_pkg::PCT_W-1:0]  pct_next;

    ips_pkg::time_t             t_edit;
    logic [ips_pkg::MIN_OF_DAY_W-1:0] now_min;
    logic [ips_pkg::MIN_OF_DAY_W-1:0] start_min;
    logic [ips_pkg::MIN_OF_DAY_W-1:0] stop_min;

    function automatic logic [ips_pkg::MIN_OF_DAY_W-1:0] to_min(ips_pkg::time_t t);
        return ips_pkg::MIN_OF_DAY_W'(t.hour) * ips_pkg::MIN_OF_DAY_W'(60)
               + ips_pkg::MIN_OF_DAY_W'(t.minute);
    endfunction

    function automatic logic [4:0] inc_hour(logic [4:0] h);
        return (h >= ips_pkg::LAST_HOUR) ? 5'd0 : h + 5'd1;
    endfunction

    function automatic logic [4:0] dec_hour(logic [4:0] h);
        return (h == 5'd0) ? ips_pkg::LAST_HOUR : h - 5'd1;
    endfunction

    function automatic logic [5:0] inc_minute(logic [5:0] m);
        return (m >= ips_pkg::LAST_MINUTE) ? 6'd0 : m + 6'd1;
    endfunction

    function automatic logic [5:0] dec_minute(logic [5:0] m);
        return (m == 6'd0) ? ips_pkg::LAST_MINUTE : m - 6'd1;
    endfunction

    // After the start moves up, a stop at or before it is pushed to start plus one minute.
    function automatic ips_pkg::time_t start_fix(ips_pkg::time_t s, ips_pkg::time_t e);
        ips_pkg::time_t r;
        r = e;
        if (to_min(s) >= to_min(e))
        begin
            r.hour   = s.hour;
            r.minute = inc_minute(s.minute);
            if (r.minute == 6'd0)
            begin
                r.hour = inc_hour(s.hour);
            end
        end
        return r;
    endfunction

    assign now_min   = to_min('{hour: ev.hour, minute: ev.minute});
    assign start_min = to_min(start_reg);
    assign stop_min  = to_min(stop_reg);

    always_comb
    begin
        pump_next  = pump_reg;
        mode_next  = mode_reg;
        phase_next = phase_reg;
        start_next = start_reg;
        stop_next  = stop_reg;
        pct_next   = pct_reg;
        t_edit     = start_reg;
        if (ev.op == ips_pkg::OP_TICK)
        begin
            pct_next = ev.percent;
            if (!mode_reg)
            begin
                if (ev.percent < low_thr)
                begin
                    pump_next = 1'b1;
                end
                else if (ev.percent >= opt_thr)
                begin
                    pump_next = 1'b0;
                end
            end
            else if (phase_reg == ips_pkg::PH_NORMAL)
            begin
                // A start later than the stop means the window runs past midnight.
                if (start_min <= stop_min)
                begin
                    pump_next = (now_min >= start_min) && (now_min < stop_min);
                end
                else
                begin
                    pump_next = (now_min >= start_min) || (now_min < stop_min);
                end
            end
        end
        else if (ev.button == ips_pkg::BTN_MODE)
        begin
            mode_next  = !mode_reg;
            phase_next = ips_pkg::PH_NORMAL;
        end
        else if (mode_reg && (ev.button <= ips_pkg::BTN_RIGHT))
        begin
            case (phase_reg)
                ips_pkg::PH_NORMAL:
                begin
                    if (ev.button == ips_pkg::BTN_RIGHT)
                    begin
                        phase_next = ips_pkg::PH_START_HOUR;
                    end
                end
                ips_pkg::PH_START_HOUR:
                begin
                    if (ev.button == ips_pkg::BTN_UP)
                    begin
                        t_edit.hour = inc_hour(start_reg.hour);
                        start_next  = t_edit;
                        stop_next   = start_fix(t_edit, stop_reg);
                    end
                    else if (ev.button == ips_pkg::BTN_DOWN)
                    begin
                        start_next.hour = dec_hour(start_reg.hour);
                    end
                    else if (ev.button == ips_pkg::BTN_RIGHT)
                    begin
                        phase_next = ips_pkg::PH_START_MIN;
                    end
                    else
                    begin
                        phase_next = ips_pkg::PH_NORMAL;
                    end
                end
                ips_pkg::PH_START_MIN:
                begin
                    if (ev.button == ips_pkg::BTN_UP)
                    begin
                        t_edit.minute = inc_minute(start_reg.minute);
                        if (t_edit.minute == 6'd0)
                        begin
                            t_edit.hour = inc_hour(start_reg.hour);
                        end
                        start_next = t_edit;
                        stop_next  = start_fix(t_edit, stop_reg);
                    end
                    else if (ev.button == ips_pkg::BTN_DOWN)
                    begin
                        if (start_reg.minute == 6'd0)
                        begin
                            start_next.hour = dec_hour(start_reg.hour);
                        end
                        start_next.minute = dec_minute(start_reg.minute);
                    end
                    else if (ev.button == ips_pkg::BTN_RIGHT)
                    begin
                        phase_next = ips_pkg::PH_STOP_HOUR;
                    end
                    else
                    begin
                        phase_next = ips_pkg::PH_START_HOUR;
                    end
                end
                ips_pkg::PH_STOP_HOUR:
                begin
                    if (ev.button == ips_pkg::BTN_UP)
                    begin
                        stop_next.hour = inc_hour(stop_reg.hour);
                    end
                    else if (ev.button == ips_pkg::BTN_DOWN)
                    begin
                        t_edit      = stop_reg;
                        t_edit.hour = dec_hour(stop_reg.hour);
                        if (to_min(t_edit) > start_min)
                        begin
                            stop_next = t_edit;
                        end
                    end
                    else if (ev.button == ips_pkg::BTN_RIGHT)
                    begin
                        phase_next = ips_pkg::PH_STOP_MIN;
                    end
                    else
                    begin
                        phase_next = ips_pkg::PH_START_MIN;
                    end
                end
                ips_pkg::PH_STOP_MIN:
                begin
                    if (ev.button == ips_pkg::BTN_UP)
                    begin
                        stop_next.minute = inc_minute(stop_reg.minute);
                        if (stop_next.minute == 6'd0)
                        begin
                            stop_next.hour = inc_hour(stop_reg.hour);
                        end
                    end
                    else if (ev.button == ips_pkg::BTN_DOWN)
                    begin
                        t_edit = stop_reg;
                        if (stop_reg.minute == 6'd0)
                        begin
                            t_edit.hour = dec_hour(stop_reg.hour);
                        end
                        t_edit.minute = dec_minute(stop_reg.minute);
                        if (to_min(t_edit) > start_min)
                        begin
                            stop_next = t_edit;
                        end
                    end
                    else if (ev.button == ips_pkg::BTN_RIGHT)
                    begin
                        phase_next = ips_pkg::PH_NORMAL;
                    end
                    else
                    begin
                        phase_next = ips_pkg::PH_STOP_HOUR;
                    end
                end
                default:
                begin
                    phase_next = ips_pkg::PH_NORMAL;
                end
            endcase
        end
    end

    // The result shows the state as it stands after the event.
    always_comb
    begin
        res.pump_on          = pump_next;
        res.moisture_percent = pct_next;
        res.timed_mode       = mode_next;
        res.editor_state     = phase_next;
        res.start_time       = start_next;
        res.stop_time        = stop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_reg         <= 1'b0;
            mode_reg         <= 1'b0;
            phase_reg        <= ips_pkg::PH_NORMAL;
            start_reg.hour   <= ips_pkg::START_HOUR_RST;
            start_reg.minute <= ips_pkg::START_MINUTE_RST;
            stop_reg.hour    <= ips_pkg::STOP_HOUR_RST;
            stop_reg.minute  <= ips_pkg::STOP_MINUTE_RST;
            pct_reg          <= '0;
        end
        else if (fire)
        begin
            pump_reg  <= pump_next;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            start_reg <= start_next;
            stop_reg  <= stop_next;
            pct_reg   <= pct_next;
        end
    end

endmodule
